// File: rtl/oggpf_pkg.sv
// ----------------------------------------------------------------------------
// oggpf_pkg
// shared types, constants and functions of the ogg opus page framer
// ----------------------------------------------------------------------------
package oggpf_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 61440;
  localparam int unsigned ADDR_W = $clog2(MAX_PACKET_BYTES);
  localparam int unsigned CNT_W  = $clog2(MAX_PACKET_BYTES + 1);

  localparam logic [31:0] OGG_POLY     = 32'h04C1_1DB7;
  localparam logic [31:0] SERIAL_RESET = 32'h4F70_7573;
  localparam logic [31:0] OGGS_MAGIC   = 32'h5367_674F;  // "OggS", first char lowest
  localparam logic [4:0]  HDR_LAST     = 5'd26;
  localparam logic [7:0]  LACE_MAX     = 8'd255;
  localparam logic [7:0]  LACE_TOP     = 8'd254;

  localparam logic [1:0] FC_ONE   = 2'd0;
  localparam logic [1:0] FC_TWO_A = 2'd1;
  localparam logic [1:0] FC_TWO_B = 2'd2;
  localparam logic [1:0] FC_ARB   = 2'd3;

  localparam logic [11:0] FRAME_SAMPLES [32] = '{
    12'd480, 12'd960, 12'd1920, 12'd2880, 12'd480, 12'd960, 12'd1920, 12'd2880,
    12'd480, 12'd960, 12'd1920, 12'd2880, 12'd480, 12'd960, 12'd480,  12'd960,
    12'd120, 12'd240, 12'd480,  12'd960,  12'd120, 12'd240, 12'd480,  12'd960,
    12'd120, 12'd240, 12'd480,  12'd960,  12'd120, 12'd240, 12'd480,  12'd960
  };

  typedef struct packed {
    logic collect;
    logic samp;
    logic gran;
    logic crc_clr;
    logic hdr_feed;
    logic seg_feed;
    logic pay_rd;
    logic idx_clr;
    logic idx_inc;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic overflow;
    logic hdr_last;
    logic seg_last;
    logic pay_last;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ OGG_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/oggpf_ctrl.sv
// ----------------------------------------------------------------------------
// oggpf_ctrl
// sequencer: collect packet, granule update, crc over header, lacing, payload
// ----------------------------------------------------------------------------
module oggpf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  oggpf_pkg::stat_t stat,
  output oggpf_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_COLLECT = 8'b0000_0001,
    S_SAMP    = 8'b0000_0010,
    S_GRAN    = 8'b0000_0100,
    S_HDR     = 8'b0000_1000,
    S_SEG     = 8'b0001_0000,
    S_PAY     = 8'b0010_0000,
    S_DRAIN   = 8'b0100_0000,
    S_LOAD    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   beat;

  assign in_tready = (state_r == S_COLLECT);
  assign beat      = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_COLLECT: begin
        cmd.collect = beat;
        if (beat && in_tlast) state_nxt = S_SAMP;
      end
      S_SAMP: begin
        cmd.samp    = 1'b1;
        cmd.crc_clr = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt   = stat.overflow ? S_LOAD : S_GRAN;
      end
      S_GRAN: begin
        cmd.gran  = 1'b1;
        state_nxt = S_HDR;
      end
      S_HDR: begin
        cmd.hdr_feed = 1'b1;
        if (stat.hdr_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SEG;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SEG: begin
        cmd.seg_feed = 1'b1;
        if (stat.seg_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PAY;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PAY: begin
        cmd.pay_rd  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.pay_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_COLLECT;
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/oggpf_dp.sv
// ----------------------------------------------------------------------------
// oggpf_dp
// datapath: payload memory, packet counters, granule, crc unit, result register
// ----------------------------------------------------------------------------
module oggpf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  oggpf_pkg::cmd_t                cmd,
  output oggpf_pkg::stat_t               stat,
  input  logic [7:0]                     in_byte,
  input  logic                           cfg_we,
  input  logic [31:0]                    cfg_data,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [62:0]                    res_gran,
  output logic [31:0]                    res_seq,
  output logic [31:0]                    res_crc,
  output logic [7:0]                     res_nseg,
  output logic [7:0]                     res_fin,
  output logic [15:0]                    res_size,
  output logic                           res_long
);

  logic [7:0] mem [oggpf_pkg::MAX_PACKET_BYTES];
  logic [7:0] mem_q;

  logic [oggpf_pkg::CNT_W-1:0] cnt_r;
  logic [oggpf_pkg::CNT_W-1:0] idx_r;
  logic [7:0]                  nseg_r, fin_r;
  logic [7:0]                  toc_r, count_r;
  logic                        ovf_r;
  logic [63:0]                 gran_r;
  logic [31:0]                 page_r;
  logic [31:0]                 serial_r;
  logic [31:0]                 crc_r;
  logic [17:0]                 samples_r;
  logic                        rd_valid_r;
  logic                        out_valid_r;

  logic        store;
  logic [5:0]  mult;
  logic [215:0] hdr_vec;
  logic [7:0]  hdr_byte;
  logic [7:0]  seg_byte;
  logic [7:0]  seg_top;

  function automatic logic [11:0] FRAME_SPF(input logic [4:0] cfg);
    return oggpf_pkg::FRAME_SAMPLES[cfg];
  endfunction

  assign store = cmd.collect && (cnt_r < oggpf_pkg::CNT_W'(oggpf_pkg::MAX_PACKET_BYTES));

  always_comb begin
    case (toc_r[1:0]) inside
      oggpf_pkg::FC_ONE:   mult = 6'd1;
      oggpf_pkg::FC_TWO_A,
      oggpf_pkg::FC_TWO_B: mult = 6'd2;
      default:             mult = (cnt_r < oggpf_pkg::CNT_W'(2)) ? 6'd1 : count_r[5:0];
    endcase
  end

  assign hdr_vec  = {nseg_r, 32'h0, page_r, serial_r, gran_r, 16'h0, oggpf_pkg::OGGS_MAGIC};
  assign hdr_byte = hdr_vec[{idx_r[4:0], 3'b000} +: 8];
  assign seg_top  = nseg_r - 8'd1;
  assign seg_byte = (idx_r[7:0] == seg_top) ? fin_r : oggpf_pkg::LACE_MAX;

  assign stat.overflow = ovf_r;
  assign stat.hdr_last = (idx_r[4:0] == oggpf_pkg::HDR_LAST);
  assign stat.seg_last = (idx_r[7:0] == seg_top);
  assign stat.pay_last = (idx_r == cnt_r - oggpf_pkg::CNT_W'(1));
  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;

  // payload memory
  always_ff @(posedge clk) begin
    if (store) mem[cnt_r[oggpf_pkg::ADDR_W-1:0]] <= in_byte;
    mem_q <= mem[idx_r[oggpf_pkg::ADDR_W-1:0]];
  end

  // packet state and stream counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nseg_r      <= 8'd1;
      fin_r       <= '0;
      toc_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      gran_r      <= '0;
      page_r      <= '0;
      serial_r    <= oggpf_pkg::SERIAL_RESET;
      idx_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) serial_r <= cfg_data;
      rd_valid_r <= cmd.pay_rd;

      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + oggpf_pkg::CNT_W'(1);

      if (cmd.collect) begin
        if (store) begin
          if (cnt_r == '0) toc_r <= in_byte;
          if (cnt_r == oggpf_pkg::CNT_W'(1)) count_r <= in_byte;
          cnt_r <= cnt_r + oggpf_pkg::CNT_W'(1);
          if (fin_r == oggpf_pkg::LACE_TOP) begin
            fin_r  <= '0;
            nseg_r <= nseg_r + 8'd1;
          end else begin
            fin_r <= fin_r + 8'd1;
          end
        end else begin
          ovf_r <= 1'b1;
        end
      end

      if (cmd.gran) gran_r <= gran_r + 64'(samples_r);

      if (cmd.load) begin
        out_valid_r <= 1'b1;
        if (!ovf_r) page_r <= page_r + 32'd1;
        cnt_r   <= '0;
        nseg_r  <= 8'd1;
        fin_r   <= '0;
        toc_r   <= '0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sample count, crc unit and result register
  always_ff @(posedge clk) begin
    if (cmd.samp) samples_r <= 18'(FRAME_SPF(toc_r[7:3])) * 18'(mult);

    if (cmd.crc_clr)       crc_r <= '0;
    else if (cmd.hdr_feed) crc_r <= oggpf_pkg::crc_byte(crc_r, hdr_byte);
    else if (cmd.seg_feed) crc_r <= oggpf_pkg::crc_byte(crc_r, seg_byte);
    else if (rd_valid_r)   crc_r <= oggpf_pkg::crc_byte(crc_r, mem_q);

    if (cmd.load) begin
      res_gran <= gran_r[62:0];
      res_seq  <= page_r;
      res_long <= ovf_r;
      res_crc  <= ovf_r ? 32'h0 : crc_r;
      res_nseg <= ovf_r ? 8'h0 : nseg_r;
      res_fin  <= ovf_r ? 8'h0 : fin_r;
      res_size <= ovf_r ? 16'h0 : 16'(cnt_r);
    end
  end

endmodule

// File: rtl/ogg_opus_audio_page_framer.sv
// ----------------------------------------------------------------------------
// ogg_opus_audio_page_framer
// frames one opus packet per ogg audio page and reports the page header facts
// ----------------------------------------------------------------------------
// input beats are taken one per cycle while a packet is collected
// after the last beat the page passes the sample count, granule update, 27 header
// bytes, lacing table and one memory read per payload byte for the crc pass
// before the result beat is offered; an overlong packet goes straight to the result
// the next packet is collected while an earlier result waits to be taken
// rst_n (synchronous) clears counters, restores the serial number, empties output
// ----------------------------------------------------------------------------
module ogg_opus_audio_page_framer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // payload_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // granule_position, page_sequence, page_crc,
                                   // segment_count, final_segment_size,
                                   // payload_size, zero pad
  output logic         out_tuser,  // too_long
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data    // serial_number
);

  oggpf_pkg::cmd_t  cmd;
  oggpf_pkg::stat_t stat;

  logic [62:0] res_gran;
  logic [31:0] res_seq, res_crc;
  logic [7:0]  res_nseg, res_fin;
  logic [15:0] res_size;
  logic        res_long;

  assign cfg_ready = 1'b1;

  oggpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oggpf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_gran   (res_gran),
    .res_seq    (res_seq),
    .res_crc    (res_crc),
    .res_nseg   (res_nseg),
    .res_fin    (res_fin),
    .res_size   (res_size),
    .res_long   (res_long)
  );

  assign out_tdata = {1'b0, res_size, res_fin, res_nseg, res_crc, res_seq, res_gran};
  assign out_tuser = res_long;

  a_long_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[158:95] == 64'h0)
    else $error("flagged page carries crc or size");

  a_size_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[158:143] != 16'h0 && out_tdata[142:135] != 8'hFF
                                 && out_tdata[134:127] != 8'h0)
    else $error("bad lacing or size on page");

  a_no_take_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_tvalid && !out_tready))
    else $error("result overwritten before taken");

  a_ready_collect : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.pay_rd && !cmd.hdr_feed && !cmd.seg_feed)
    else $error("input taken during crc pass");

endmodule
